>>> src/assert_macros.svh
// Assertion helpers: every property is clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

>>> src/ibcrc_pkg.sv
package ibcrc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;

  localparam logic [CRC_W-1:0]  CRC_POLY_REFL = 16'hA001;
  localparam logic [BYTE_W-1:0] BYTE_INVERT   = 8'hFF;
  localparam logic [CRC_W-1:0]  CRC_INIT      = 16'h0000;

  // Fold one byte into the reflected CRC register, LSB first.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY_REFL;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> src/ibcrc_in_if.sv
interface ibcrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ibcrc_pkg::BYTE_W-1:0]  data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/ibcrc_out_if.sv
interface ibcrc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ibcrc_pkg::CRC_W-1:0]  crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

>>> src/inverted_byte_crc16.sv
// CRC-16/ARC (poly 0x8005 reflected, init 0, no final XOR) over the bitwise
// inverse of each message byte. One byte is taken per cycle on msg; the byte
// flagged last_byte closes the message, its CRC is returned as one transfer on
// crc, and the running register restarts at zero for the next message. The
// block sustains one byte per clock unless input stalls: the 8-bit unrolled
// CRC update sits between the input register and the running CRC/result
// register, so a last byte passes the input register and then the result
// register before its result is valid on crc. Input stalls only when a last
// byte arrives while a previous result still waits on crc.
module inverted_byte_crc16 (
  input  logic        clk,
  input  logic        rst,
  ibcrc_in_if.sink    msg,
  ibcrc_out_if.source crc
);

  ibcrc_in_if stage_ch ();

  ibcrc_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .msg   (msg),
    .stage (stage_ch.source)
  );

  ibcrc_fold_stage u_fold_stage (
    .clk   (clk),
    .rst   (rst),
    .stage (stage_ch.sink),
    .crc   (crc)
  );

endmodule

>>> src/ibcrc_in_stage.sv
module ibcrc_in_stage (
  input  logic        clk,
  input  logic        rst,
  ibcrc_in_if.sink    msg,
  ibcrc_in_if.source  stage
);
  import ibcrc_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  // Take a new byte whenever the register is empty or drains this cycle.
  assign msg.ready = !valid || stage.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (msg.ready) begin
      valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      data_byte <= msg.data_byte;
      last_byte <= msg.last_byte;
    end
  end

  assign stage.valid     = valid;
  assign stage.data_byte = data_byte;
  assign stage.last_byte = last_byte;

endmodule

>>> src/ibcrc_fold_stage.sv
`include "assert_macros.svh"

module ibcrc_fold_stage (
  input  logic        clk,
  input  logic        rst,
  ibcrc_in_if.sink    stage,
  ibcrc_out_if.source crc
);
  import ibcrc_pkg::*;

  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] crc_next;
  logic [CRC_W-1:0] crc_value;
  logic             out_valid;
  logic             xfer;

  assign crc_next = crc_fold(running_crc, stage.data_byte ^ BYTE_INVERT);

  // A last byte needs room in the result register; other bytes always go.
  assign stage.ready = !stage.last_byte || !out_valid || crc.ready;
  assign xfer        = stage.valid && stage.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      out_valid   <= 1'b0;
    end else begin
      if (xfer) begin
        running_crc <= stage.last_byte ? CRC_INIT : crc_next;
      end
      if (xfer && stage.last_byte) begin
        out_valid <= 1'b1;
      end else if (crc.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && stage.last_byte) begin
      crc_value <= crc_next;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = crc_value;

  `ASSERT_NEXT(a_clear_after_last, xfer && stage.last_byte, running_crc == CRC_INIT)
  `ASSERT_NEXT(a_result_loaded, xfer && stage.last_byte, out_valid && (crc_value == $past(crc_next)))
  `ASSERT_NEXT(a_no_spurious_result, !out_valid && !(xfer && stage.last_byte), !out_valid)
  `ASSERT_NOW(a_stall_only_on_last, stage.valid && !stage.ready, stage.last_byte && out_valid)

endmodule
